// ----- design/vca_pkg.sv -----
// Shared types, codes and helper functions for the voice channel allocator.
// Used by vca_scan and voice_channel_allocator_core; depends on nothing else.

package vca_pkg;

   localparam int ENTITY_W = 10;
   localparam int CLASS_W  = 4;
   localparam int TIME_W   = 32;
   localparam int CHIDX_W  = 5;

   localparam logic MODE_ALLOCATE = 1'b0;
   localparam logic MODE_RELEASE  = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_AUTO         = 4'd0;
   localparam logic [CLASS_W-1:0] CLASS_LESS_ATTEN   = 4'd1;
   localparam logic [CLASS_W-1:0] CLASS_VOICE        = 4'd2;
   localparam logic [CLASS_W-1:0] CLASS_VOICE_ATTEN  = 4'd3;
   localparam logic [CLASS_W-1:0] CLASS_VOICE_GLOBAL = 4'd4;

   // One stored channel entry; the busy bit is held separately in flip-flops.
   typedef struct packed {
      logic [ENTITY_W-1:0] entity;
      logic [CLASS_W-1:0]  chan_class;
      logic                loop;
      logic [TIME_W-1:0]   start;
   } entry_type;

   typedef struct packed {
      logic matched;
      logic was_busy;
   } scan_flags_type;

   function automatic logic is_voice(input logic [CLASS_W-1:0] c);
      return (c == CLASS_VOICE) || (c == CLASS_VOICE_ATTEN) || (c == CLASS_VOICE_GLOBAL);
   endfunction

   function automatic logic classes_match(input logic [CLASS_W-1:0] a,
                                          input logic [CLASS_W-1:0] b);
      return (a == b) || (is_voice(a) && is_voice(b));
   endfunction

   function automatic logic is_free_only(input logic [CLASS_W-1:0] c);
      return (c == CLASS_AUTO) || (c == CLASS_LESS_ATTEN);
   endfunction

endpackage

// ----- design/vca_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; used for the channel entry table.

module vca_ram #(
   parameter int WIDTH = 47,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/vca_scan.sv -----
// Per-entry compare unit: looks at one channel entry a cycle and keeps the
// first same-source match, the first idle channel and the oldest candidate.
// Depends on vca_pkg.

module vca_scan #(
   parameter int NUM_CHANNELS = 32,
   localparam int IDX_W = $clog2(NUM_CHANNELS)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              entry_valid,
   input  logic [IDX_W-1:0]                  entry_index,
   input  vca_pkg::entry_type                entry,
   input  logic                              entry_busy,
   input  logic [vca_pkg::ENTITY_W-1:0]      req_entity,
   input  logic [vca_pkg::CLASS_W-1:0]       req_class,
   input  logic [vca_pkg::ENTITY_W-1:0]      listener,
   output logic [IDX_W-1:0]                  victim,
   output vca_pkg::scan_flags_type           flags
);

   logic                            match_found_ff, match_found_in;
   logic [IDX_W-1:0]                match_idx_ff, match_idx_in;
   logic                            match_busy_ff, match_busy_in;
   logic                            idle_found_ff, idle_found_in;
   logic [IDX_W-1:0]                idle_idx_ff, idle_idx_in;
   logic [IDX_W-1:0]                cand_idx_ff, cand_idx_in;
   logic [vca_pkg::TIME_W-1:0]      cand_start_ff, cand_start_in;

   logic match_hit;
   logic skip;
   logic older;

   assign match_hit = (entry.entity == req_entity)
                      && vca_pkg::classes_match(entry.chan_class, req_class);
   // The listener's busy channels are protected from other entities, and
   // looping channels are skipped by the oldest search, except channel 0.
   assign skip = ((entry.entity == listener) && (req_entity != listener) && entry_busy)
                 || entry.loop;
   assign older = entry.start < cand_start_ff;

   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      match_busy_in  = match_busy_ff;
      idle_found_in  = idle_found_ff;
      idle_idx_in    = idle_idx_ff;
      cand_idx_in    = cand_idx_ff;
      cand_start_in  = cand_start_ff;
      if (clear) begin
         match_found_in = 1'b0;
         idle_found_in  = 1'b0;
      end else if (entry_valid) begin
         if (!match_found_ff && match_hit) begin
            match_found_in = 1'b1;
            match_idx_in   = entry_index;
            match_busy_in  = entry_busy;
         end
         if (!idle_found_ff && !entry_busy) begin
            idle_found_in = 1'b1;
            idle_idx_in   = entry_index;
         end
         // Channel 0 is the starting candidate even when it is protected.
         if (entry_index == '0) begin
            cand_idx_in   = entry_index;
            cand_start_in = entry.start;
         end else if (!skip && older) begin
            cand_idx_in   = entry_index;
            cand_start_in = entry.start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         idle_found_ff  <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         idle_found_ff  <= idle_found_in;
      end
      match_idx_ff  <= match_idx_in;
      match_busy_ff <= match_busy_in;
      idle_idx_ff   <= idle_idx_in;
      cand_idx_ff   <= cand_idx_in;
      cand_start_ff <= cand_start_in;
   end

   // The oldest candidate is only used when no channel is idle, so it is
   // always a busy one.
   always_comb begin
      priority if (!vca_pkg::is_free_only(req_class) && match_found_ff) begin
         victim         = match_idx_ff;
         flags.matched  = 1'b1;
         flags.was_busy = match_busy_ff;
      end else if (idle_found_ff) begin
         victim         = idle_idx_ff;
         flags.matched  = 1'b0;
         flags.was_busy = 1'b0;
      end else begin
         victim         = cand_idx_ff;
         flags.matched  = 1'b0;
         flags.was_busy = 1'b1;
      end
   end

endmodule

// ----- design/voice_channel_allocator_core.sv -----
// Voice channel allocator: top level with the scan sequencer, busy flags,
// channel table and result register. Depends on vca_pkg, vca_ram, vca_scan.
//
// Usage:
//   A request (req_valid/req_ready) either allocates a playback channel for a
//   new sound or releases one. Each request produces exactly one response on
//   rsp_valid/rsp_ready, in order. req_ready is high only while the sequencer
//   is idle; one request is handled at a time.
//   An allocation reads every channel entry once, one per cycle through the
//   single read port of the channel table, and then answers from the finish
//   state; the next request is taken once the sequencer is idle again. A
//   release skips the scan and goes straight to the finish state, where it is
//   answered.
//   The response is held in an output register; a new request may be accepted
//   while it waits. If the receiver stalls, the next request finishes its
//   scan, if any, and then waits until the held response has been taken.
//   Reset marks every channel idle and clears the listener entity; no
//   clearing pass is needed, as idle entries read as zero.
//   csr_write_enable writes the listener entity; the user must write it only
//   while the block is idle; the block itself does not enforce this.

module voice_channel_allocator_core #(
   parameter int NUM_CHANNELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [9:0]  req_source_entity,
   input  logic [3:0]  req_channel_class,
   input  logic        req_is_looping,
   input  logic [31:0] req_start_time,
   input  logic [4:0]  req_release_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_channel_index,
   output logic        rsp_same_source_replaced,
   output logic        rsp_took_free,
   output logic        rsp_evicted_busy,
   input  logic        csr_write_enable,
   input  logic [9:0]  csr_write_data
);

   localparam int IDX_W  = $clog2(NUM_CHANNELS);
   localparam int WIDE_W = (IDX_W > vca_pkg::CHIDX_W) ? IDX_W : vca_pkg::CHIDX_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [IDX_W-1:0]              addr_ff, addr_in;
   logic                          issued_all_ff, issued_all_in;
   logic                          rd_vld_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   logic                          rd_busy_ff;
   logic [NUM_CHANNELS-1:0]       busy_ff, busy_in;
   logic [vca_pkg::ENTITY_W-1:0]  listener_ff;

   logic                          mode_ff;
   logic [vca_pkg::ENTITY_W-1:0]  entity_ff;
   logic [vca_pkg::CLASS_W-1:0]   class_ff;
   logic                          loop_ff;
   logic [vca_pkg::TIME_W-1:0]    start_ff;
   logic [vca_pkg::CHIDX_W-1:0]   rel_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [vca_pkg::CHIDX_W-1:0]   rsp_idx_ff;
   logic                          rsp_same_ff;
   logic                          rsp_free_ff;
   logic                          rsp_evict_ff;

   logic                          req_accept;
   logic                          issue;
   logic                          finish_fire;
   logic                          rel_in_range;
   logic [WIDE_W-1:0]             rel_wide;
   logic [IDX_W-1:0]              rel_idx;
   logic [WIDE_W-1:0]             victim_wide;
   logic [IDX_W-1:0]              victim;
   vca_pkg::scan_flags_type       flags;
   vca_pkg::entry_type            ram_q;
   vca_pkg::entry_type            scan_entry;
   vca_pkg::entry_type            new_entry;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign issue       = (state_ff == ST_SCAN) && !issued_all_ff;
   assign finish_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign rel_in_range = 32'(rel_ff) < 32'(NUM_CHANNELS);
   assign rel_wide     = WIDE_W'(rel_ff);
   assign rel_idx      = rel_wide[IDX_W-1:0];
   assign victim_wide  = WIDE_W'(victim);

   // An idle entry reads as all zero, whatever the table still holds.
   assign scan_entry = rd_busy_ff ? ram_q : '0;

   assign new_entry.entity     = entity_ff;
   assign new_entry.chan_class = class_ff;
   assign new_entry.loop       = loop_ff;
   assign new_entry.start      = start_ff;

   vca_ram #(
      .WIDTH ($bits(vca_pkg::entry_type)),
      .DEPTH (NUM_CHANNELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (finish_fire && (mode_ff == vca_pkg::MODE_ALLOCATE)),
      .wr_addr (victim),
      .wr_data (new_entry),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (ram_q)
   );

   vca_scan #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (req_accept),
      .entry_valid (rd_vld_ff),
      .entry_index (rd_idx_ff),
      .entry       (scan_entry),
      .entry_busy  (rd_busy_ff),
      .req_entity  (entity_ff),
      .req_class   (class_ff),
      .listener    (listener_ff),
      .victim      (victim),
      .flags       (flags)
   );

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      issued_all_in = issued_all_ff;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in       = '0;
            issued_all_in = 1'b0;
            if (req_accept) begin
               state_in = (req_mode == vca_pkg::MODE_RELEASE) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               if (addr_ff == LAST_IDX) begin
                  issued_all_in = 1'b1;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      if (finish_fire) begin
         if (mode_ff == vca_pkg::MODE_RELEASE) begin
            if (rel_in_range) begin
               busy_in[rel_idx] = 1'b0;
            end
         end else begin
            busy_in[victim] = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_all_ff <= 1'b0;
         rd_vld_ff     <= 1'b0;
         busy_ff       <= '0;
         listener_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issued_all_ff <= issued_all_in;
         rd_vld_ff     <= issue;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            listener_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      rd_idx_ff  <= addr_ff;
      rd_busy_ff <= busy_ff[addr_ff];
      if (req_accept) begin
         mode_ff   <= req_mode;
         entity_ff <= req_source_entity;
         class_ff  <= req_channel_class;
         loop_ff   <= req_is_looping;
         start_ff  <= req_start_time;
         rel_ff    <= req_release_index;
      end
      if (finish_fire) begin
         if (mode_ff == vca_pkg::MODE_RELEASE) begin
            rsp_idx_ff   <= rel_ff;
            rsp_same_ff  <= 1'b0;
            rsp_free_ff  <= 1'b0;
            rsp_evict_ff <= 1'b0;
         end else begin
            rsp_idx_ff   <= victim_wide[vca_pkg::CHIDX_W-1:0];
            rsp_same_ff  <= flags.matched;
            rsp_free_ff  <= !flags.was_busy;
            rsp_evict_ff <= flags.was_busy && !flags.matched;
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_channel_index        = rsp_idx_ff;
   assign rsp_same_source_replaced = rsp_same_ff;
   assign rsp_took_free            = rsp_free_ff;
   assign rsp_evicted_busy         = rsp_evict_ff;

endmodule
